@@ hw/rtl/sopt_pkg.sv @@
package sopt_pkg;

  localparam int KEY_W      = 32;
  localparam int OFFSET_W   = 32;
  localparam int COUNT_W    = 13;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 48;

  // command carried in in_tuser
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]    left_key;
    logic [KEY_W-1:0]    right_key;
    logic [OFFSET_W-1:0] offset;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_CHECK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_FINISH
  } state_t;

endpackage

@@ hw/rtl/sopt_ram.sv @@
module sopt_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/sorted_pair_offset_table_unit.sv @@
// Channel | dir | tdata (low bit up)                                  | tuser
// in_     | in  | left_key 32, right_key 32, offset_value 32,          | cmd
//         |     | cumulative 1, 7 zero bits                           |
// out_    | out | found 1, offset_out 32, status 1, entry_count 13,    | -
//         |     | 1 zero bit                                          |
//
// One word at a time. A binary search over the stored pairs reads each probe through
// the single read port of the entry memory, for lookups and updates alike.
// Insert and erase then shift entries one at a time, each with a read and then a write:
// erase pulls the entries above the pair down, insert pushes those at and above the slot up.
// Synchronous reset empties the table by clearing the count; the memory is not swept.
// A finished result waits in the output register; in_tready returns once it is loaded.
module sorted_pair_offset_table_unit #(
  parameter int CAPACITY = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sopt_pkg::IN_DATA_W-1:0]  in_tdata,  // left_key, right_key, offset_value, cumulative
  input  logic                            in_tuser,  // cmd
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sopt_pkg::OUT_DATA_W-1:0] out_tdata  // found, offset_out, status, entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam int KW = sopt_pkg::KEY_W;
  localparam int OW = sopt_pkg::OFFSET_W;

  sopt_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]     mid_r, mid_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              remove_r, remove_nxt;

  logic              cmd_r, cmd_nxt;
  logic [2*KW-1:0]   probe_r, probe_nxt;
  logic [OW-1:0]     ov_r, ov_nxt;
  logic              cum_r, cum_nxt;

  logic              res_found_r, res_found_nxt;
  logic [OW-1:0]     res_off_r, res_off_nxt;
  logic              res_status_r, res_status_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [OW-1:0]     out_off_r, out_off_nxt;
  logic              out_status_r, out_status_nxt;
  logic [sopt_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  logic              wr_en, rd_en;
  logic [CW-1:0]     wr_pos, rd_pos;
  logic [AW-1:0]     wr_addr, rd_addr;
  sopt_pkg::entry_t  wr_entry, rd_entry;
  logic [sopt_pkg::ENTRY_W-1:0] rd_word;

  logic [CW-1:0]     mid_calc;
  logic [CW-1:0]     idx_inc, idx_dec;
  logic [2*KW-1:0]   rd_key;
  logic              hit;

  assign wr_addr  = wr_pos[AW-1:0];
  assign rd_addr  = rd_pos[AW-1:0];
  assign rd_entry = sopt_pkg::entry_t'(rd_word);
  assign rd_key   = {rd_entry.left_key, rd_entry.right_key};
  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);
  assign idx_inc  = idx_r + CW'(1);
  assign idx_dec  = idx_r - CW'(1);
  assign hit      = (lo_r < count_r) && (rd_key == probe_r);

  sopt_ram #(
    .WIDTH (sopt_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sopt_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    idx_r        <= idx_nxt;
    remove_r     <= remove_nxt;
    cmd_r        <= cmd_nxt;
    probe_r      <= probe_nxt;
    ov_r         <= ov_nxt;
    cum_r        <= cum_nxt;
    res_found_r  <= res_found_nxt;
    res_off_r    <= res_off_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_off_r    <= out_off_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    idx_nxt        = idx_r;
    remove_nxt     = remove_r;
    cmd_nxt        = cmd_r;
    probe_nxt      = probe_r;
    ov_nxt         = ov_r;
    cum_nxt        = cum_r;
    res_found_nxt  = res_found_r;
    res_off_nxt    = res_off_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_off_nxt    = out_off_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    in_tready      = 1'b0;
    wr_en          = 1'b0;
    wr_pos         = idx_r;
    wr_entry       = rd_entry;
    rd_en          = 1'b0;
    rd_pos         = mid_calc;

    unique case (state_r)
      sopt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          // left key is the major half of the search key
          probe_nxt = {in_tdata[KW-1:0], in_tdata[2*KW-1:KW]};
          ov_nxt    = in_tdata[2*KW+OW-1:2*KW];
          cum_nxt   = in_tdata[2*KW+OW];
          lo_nxt    = '0;
          hi_nxt    = count_r;
          state_nxt = sopt_pkg::ST_PROBE;
        end
      end

      sopt_pkg::ST_PROBE: begin
        if (lo_r < hi_r) begin
          rd_en     = 1'b1;
          rd_pos    = mid_calc;
          mid_nxt   = mid_calc;
          state_nxt = sopt_pkg::ST_CMP;
        end else begin
          // lower bound found; fetch it for the equality check
          rd_en     = (lo_r < count_r);
          rd_pos    = lo_r;
          state_nxt = sopt_pkg::ST_CHECK;
        end
      end

      sopt_pkg::ST_CMP: begin
        if (rd_key < probe_r) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = sopt_pkg::ST_PROBE;
      end

      sopt_pkg::ST_CHECK: begin
        res_found_nxt  = hit;
        res_off_nxt    = '0;
        res_status_nxt = sopt_pkg::STATUS_OK;
        state_nxt      = sopt_pkg::ST_FINISH;
        if (cmd_r == sopt_pkg::CMD_LOOKUP) begin
          if (hit) begin
            res_off_nxt = rd_entry.offset;
          end
        end else if (hit) begin
          if (ov_r != '0) begin
            wr_en           = 1'b1;
            wr_pos          = lo_r;
            wr_entry        = rd_entry;
            wr_entry.offset = cum_r ? (rd_entry.offset + ov_r) : ov_r;
          end else begin
            idx_nxt    = lo_r;
            remove_nxt = 1'b1;
            state_nxt  = sopt_pkg::ST_SHIFT_RD;
          end
        end else if (ov_r != '0) begin
          if (count_r >= CAP_C) begin
            res_status_nxt = sopt_pkg::STATUS_FULL;
          end else begin
            idx_nxt    = count_r;
            remove_nxt = 1'b0;
            state_nxt  = sopt_pkg::ST_SHIFT_RD;
          end
        end
      end

      sopt_pkg::ST_SHIFT_RD: begin
        if (remove_r) begin
          // erase: pull entries above down by one
          if (idx_inc < count_r) begin
            rd_en     = 1'b1;
            rd_pos    = idx_inc;
            state_nxt = sopt_pkg::ST_SHIFT_WR;
          end else begin
            count_nxt = count_r - CW'(1);
            state_nxt = sopt_pkg::ST_FINISH;
          end
        end else begin
          // insert: push entries at and above the slot up by one
          if (idx_r > lo_r) begin
            rd_en     = 1'b1;
            rd_pos    = idx_dec;
            state_nxt = sopt_pkg::ST_SHIFT_WR;
          end else begin
            state_nxt = sopt_pkg::ST_PUT;
          end
        end
      end

      sopt_pkg::ST_SHIFT_WR: begin
        wr_en     = 1'b1;
        wr_pos    = idx_r;
        wr_entry  = rd_entry;
        idx_nxt   = remove_r ? idx_inc : idx_dec;
        state_nxt = sopt_pkg::ST_SHIFT_RD;
      end

      sopt_pkg::ST_PUT: begin
        wr_en              = 1'b1;
        wr_pos             = lo_r;
        wr_entry.left_key  = probe_r[2*KW-1:KW];
        wr_entry.right_key = probe_r[KW-1:0];
        wr_entry.offset    = ov_r;
        count_nxt          = count_r + CW'(1);
        state_nxt          = sopt_pkg::ST_FINISH;
      end

      sopt_pkg::ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_off_nxt    = res_off_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = sopt_pkg::COUNT_W'(count_r);
          state_nxt      = sopt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = sopt_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, out_status_r, out_off_r, out_found_r};

endmodule

@@ tb/sopt_checker.sv @@
module sopt_checker
  import sopt_pkg::*;
#(
  parameter int CAPACITY = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // left_key, right_key, offset_value, cumulative
  input  logic                  in_tuser,  // cmd
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata, // found, offset_out, status, entry_count
  output int                    mismatch_count,
  output int                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // first member lands in the top bits, so found ends up at bit 0 as on out_tdata
  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic                status;
    logic [OFFSET_W-1:0] offset;
    logic                found;
  } result_t;

  entry_t  pairs[$];
  result_t due_results[$];
  int      words_in = 0;
  int      words_out = 0;
  int      errs = 0;
  result_t got;
  result_t want;

  assign mismatch_count = errs;
  assign pending_count  = words_in - words_out;

  // Applies one word to the shadow table, kept sorted on {left_key, right_key}.
  function automatic result_t apply_pair_cmd(input logic cmd, input logic [KEY_W-1:0] lk,
                                             input logic [KEY_W-1:0] rk,
                                             input logic [OFFSET_W-1:0] ov, input logic cum);
    result_t                r;
    logic [2*KEY_W-1:0]     probe;
    int                     lo;
    int                     hi;
    int                     mid;
    bit                     hit;
    entry_t                 e;
    probe = {lk, rk};
    lo = 0;
    hi = pairs.size();
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if ({pairs[mid].left_key, pairs[mid].right_key} < probe) lo = mid + 1;
      else hi = mid;
    end
    hit = (lo < pairs.size()) && ({pairs[lo].left_key, pairs[lo].right_key} == probe);
    r.found  = hit;
    r.offset = '0;
    r.status = STATUS_OK;
    if (cmd == CMD_LOOKUP) begin
      if (hit) r.offset = pairs[lo].offset;
    end else if (hit) begin
      if (ov != '0) begin
        e = pairs[lo];
        e.offset = cum ? e.offset + ov : ov;
        pairs[lo] = e;
      end else begin
        pairs.delete(lo);
      end
    end else if (ov != '0) begin
      if (pairs.size() >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        e.left_key  = lk;
        e.right_key = rk;
        e.offset    = ov;
        pairs.insert(lo, e);
      end
    end
    r.count = COUNT_W'(pairs.size());
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      words_in  <= 0;
      words_out <= 0;
    end else begin
      // a result word never belongs to the word accepted on the same edge
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[$bits(result_t)-1:0]);
        words_out <= words_out + 1;
        if (due_results.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected result word: found=%0d offset=%h status=%0d count=%0d",
                     $realtime, got.found, got.offset, got.status, got.count);
        end else begin
          want = due_results.pop_front();
          if (got.found !== want.found || got.offset !== want.offset ||
              got.status !== want.status || got.count !== want.count) begin
            errs++;
            if (errs <= 10)
              $display("%0t: result mismatch: exp found=%0d offset=%h status=%0d count=%0d, %s",
                       $realtime, want.found, want.offset, want.status, want.count,
                       $sformatf("got found=%0d offset=%h status=%0d count=%0d",
                                 got.found, got.offset, got.status, got.count));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        due_results.push_back(apply_pair_cmd(in_tuser, in_tdata[31:0], in_tdata[63:32],
                                             in_tdata[95:64], in_tdata[96]));
        words_in <= words_in + 1;
      end
    end
  end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sopt_pkg::*;

  localparam int TABLE_CAP   = 4096;
  localparam int STALL_LIMIT = 20000;
  localparam int POOL_N      = 32;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    mismatches;
  int                    pending;
  bit                    quiet = 1'b0;
  logic [KEY_W-1:0]      pool_left[POOL_N];
  logic [KEY_W-1:0]      pool_right[POOL_N];
  logic [KEY_W-1:0]      shared_left[4];

  sorted_pair_offset_table_unit #(
    .CAPACITY(TABLE_CAP)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  sopt_checker #(
    .CAPACITY(TABLE_CAP)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatch_count(mismatches),
    .pending_count (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic logic [OFFSET_W-1:0] pick_offset();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return '0;
    if (r < 35) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'hffff_ffff;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_word(input logic cmd, input logic [KEY_W-1:0] lk,
                           input logic [KEY_W-1:0] rk, input logic [OFFSET_W-1:0] ov,
                           input logic cum);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'b0, cum, ov, rk, lk};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // ends the run when no word moves on either side for too long
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("sorted_pair_offset_table_unit verification failed");
    $finish;
  end

  initial begin
    int               idx;
    logic [KEY_W-1:0] lk;
    logic [KEY_W-1:0] rk;
    logic             cmd;
    in_tvalid <= 1'b0;
    in_tuser  <= CMD_UPDATE;
    in_tdata  <= '0;
    rst_n     <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, key extremes, wrap, zero sum, erase, ignored fields
    send_word(CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b0);
    send_word(CMD_UPDATE, 32'h1234, 32'h5678, 32'h0, 1'b1);
    send_word(CMD_UPDATE, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 1'b0);
    send_word(CMD_UPDATE, 32'h0, 32'h0, 32'h8000_0000, 1'b0);
    send_word(CMD_UPDATE, 32'h0, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send_word(CMD_UPDATE, 32'hffff_ffff, 32'h0, 32'h1, 1'b0);
    send_word(CMD_UPDATE, 32'h5, 32'h3, 32'd100, 1'b0);
    send_word(CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b0);
    send_word(CMD_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 1'b0);
    send_word(CMD_LOOKUP, 32'h0, 32'hffff_ffff, 32'h0, 1'b0);
    send_word(CMD_UPDATE, 32'hffff_ffff, 32'hffff_ffff, 32'h1, 1'b1);
    send_word(CMD_UPDATE, 32'h5, 32'h3, -32'sd100, 1'b1);
    send_word(CMD_LOOKUP, 32'h5, 32'h3, 32'h0, 1'b0);
    send_word(CMD_UPDATE, 32'h0, 32'h0, 32'h1234_5678, 1'b0);
    send_word(CMD_UPDATE, 32'h0, 32'hffff_ffff, 32'h0, 1'b1);
    send_word(CMD_LOOKUP, 32'h0, 32'hffff_ffff, 32'h0, 1'b0);
    send_word(CMD_UPDATE, 32'h1, 32'h1, 32'h5, 1'b1);
    send_word(CMD_LOOKUP, 32'h1, 32'h1, 32'hffff_ffff, 1'b1);
    send_word(CMD_UPDATE, 32'h0, 32'h0, 32'h0, 1'b0);
    send_word(CMD_UPDATE, 32'h1, 32'h1, 32'h0, 1'b0);
    send_word(CMD_UPDATE, 32'h5, 32'h3, 32'h0, 1'b1);
    send_word(CMD_UPDATE, 32'hffff_ffff, 32'h0, 32'h0, 1'b0);
    send_word(CMD_UPDATE, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 1'b0);
    send_word(CMD_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 1'b0);
    drain_results();

    // random traffic over a small pool of pairs, several sharing a left key
    pool_left[0]  = 32'h0;          pool_right[0] = 32'h0;
    pool_left[1]  = 32'h0;          pool_right[1] = 32'hffff_ffff;
    pool_left[2]  = 32'hffff_ffff;  pool_right[2] = 32'h0;
    pool_left[3]  = 32'hffff_ffff;  pool_right[3] = 32'hffff_ffff;
    pool_left[4]  = 32'h8000_0000;  pool_right[4] = 32'h7fff_ffff;
    pool_left[5]  = 32'h7fff_ffff;  pool_right[5] = 32'h8000_0000;
    for (int k = 0; k < 4; k++) shared_left[k] = $urandom;
    for (int k = 6; k < POOL_N; k++) begin
      pool_left[k]  = shared_left[$urandom_range(0, 3)];
      pool_right[k] = $urandom;
    end
    for (int chunk = 0; chunk < 4; chunk++) begin
      quiet = (chunk == 2);
      for (int k = 0; k < 400; k++) begin
        if ($urandom_range(0, 99) < 8) begin
          lk = $urandom;
          rk = $urandom;
        end else begin
          idx = $urandom_range(0, POOL_N - 1);
          lk  = pool_left[idx];
          rk  = pool_right[idx];
        end
        cmd = ($urandom_range(0, 99) < 40) ? CMD_LOOKUP : CMD_UPDATE;
        send_word(cmd, lk, rk, pick_offset(), 1'($urandom));
      end
      drain_results();
    end
    quiet = 1'b0;

    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("sorted_pair_offset_table_unit verification clean");
    end else begin
      $display("sorted_pair_offset_table_unit verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/sopt_pkg.sv
hw/rtl/sopt_ram.sv
hw/rtl/sorted_pair_offset_table_unit.sv
tb/sopt_checker.sv
tb/tb_top.sv
